### rtl/core/q2rm_pkg.sv
// q2rm_pkg: shared types and constants for the quaternion to rotation matrix unit
// request payload structs, fixed-point constants and divider sizing
// no dependencies
package q2rm_pkg;

  // one Q2.14 fraction
  localparam int unsigned Q_ONE = 16384;

  // quotient bits of the rounded element magnitude and the divider split
  localparam int unsigned QBITS = 15;
  localparam int unsigned BITS_PER_STG = 3;
  localparam int unsigned DIV_STG = QBITS / BITS_PER_STG;

  // norm, signed numerator, dividend, divisor and partial remainder widths
  localparam int unsigned NW = 33;
  localparam int unsigned NUMW = 35;
  localparam int unsigned DW = NW + QBITS;
  localparam int unsigned DVW = NW + 1;
  localparam int unsigned RW = DVW + 1;

  localparam int unsigned ELEMS = 9;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } q2rm_in_t;

  typedef struct packed {
    logic signed [15:0] m_row0_col0;
    logic signed [15:0] m_row0_col1;
    logic signed [15:0] m_row0_col2;
    logic signed [15:0] m_row1_col0;
    logic signed [15:0] m_row1_col1;
    logic signed [15:0] m_row1_col2;
    logic signed [15:0] m_row2_col0;
    logic signed [15:0] m_row2_col1;
    logic signed [15:0] m_row2_col2;
    logic               zero_norm;
  } q2rm_out_t;

endpackage

### rtl/core/quaternion_to_rotation_matrix_unit.sv
// quaternion_to_rotation_matrix_unit: Q2.14 quaternion to row-major 3x3 rotation matrix
// products, norm and numerators, then nine pipelined restoring dividers
// depends on q2rm_pkg
// pipeline: 9 register stages, in order
//   (products, sums, dividend setup, 5 divider stages of 3 quotient bits, output register)
// throughput: one request per cycle; a stalled stage holds and bubbles are squeezed out
// reset: rst_n (synchronous, active low) clears all valid bits; data registers are not reset
module quaternion_to_rotation_matrix_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  q2rm_pkg::q2rm_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output q2rm_pkg::q2rm_out_t out_data
);
  import q2rm_pkg::*;

  typedef struct packed {
    logic signed [31:0] ww;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] wz;
    logic signed [31:0] xz;
    logic signed [31:0] wy;
    logic signed [31:0] yz;
    logic signed [31:0] wx;
  } prod_t;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [QBITS-1:0] lo;
    logic [QBITS-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [ELEMS-1:0] lane;
    logic [DVW-1:0]        dv;
    logic                  zero;
  } div_stage_t;

  // ---------------- handshake chain ----------------
  logic             prod_v_r, sum_v_r, out_valid_r;
  logic [DIV_STG:0] div_v_r;
  logic [DIV_STG:0] d_rdy;
  logic             out_rdy, sum_rdy, prod_rdy;

  always_comb begin
    out_rdy = !out_valid_r || out_ready;
    d_rdy[DIV_STG] = !div_v_r[DIV_STG] || out_rdy;
    for (int k = DIV_STG - 1; k >= 0; k--) begin
      d_rdy[k] = !div_v_r[k] || d_rdy[k+1];
    end
    sum_rdy  = !sum_v_r || d_rdy[0];
    prod_rdy = !prod_v_r || sum_rdy;
  end

  assign in_ready  = prod_rdy;
  assign out_valid = out_valid_r;

  // ---------------- stage 1: products ----------------
  prod_t prod_r, prod_nxt;

  always_comb begin
    prod_nxt.ww = in_data.q_w * in_data.q_w;
    prod_nxt.xx = in_data.q_x * in_data.q_x;
    prod_nxt.yy = in_data.q_y * in_data.q_y;
    prod_nxt.zz = in_data.q_z * in_data.q_z;
    prod_nxt.xy = in_data.q_x * in_data.q_y;
    prod_nxt.wz = in_data.q_w * in_data.q_z;
    prod_nxt.xz = in_data.q_x * in_data.q_z;
    prod_nxt.wy = in_data.q_w * in_data.q_y;
    prod_nxt.yz = in_data.q_y * in_data.q_z;
    prod_nxt.wx = in_data.q_w * in_data.q_x;
  end

  always_ff @(posedge clk) begin
    if (prod_rdy) begin
      prod_r <= prod_nxt;
    end
  end

  // ---------------- stage 2: norm and numerators ----------------
  logic [NW-1:0]          n_r, n_nxt;
  logic signed [NUMW-1:0] num_r [ELEMS];
  logic signed [NUMW-1:0] num_nxt [ELEMS];

  always_comb begin
    logic signed [NUMW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
    logic signed [NUMW-1:0] n_s;
    e_ww = NUMW'(prod_r.ww);
    e_xx = NUMW'(prod_r.xx);
    e_yy = NUMW'(prod_r.yy);
    e_zz = NUMW'(prod_r.zz);
    e_xy = NUMW'(prod_r.xy);
    e_wz = NUMW'(prod_r.wz);
    e_xz = NUMW'(prod_r.xz);
    e_wy = NUMW'(prod_r.wy);
    e_yz = NUMW'(prod_r.yz);
    e_wx = NUMW'(prod_r.wx);
    n_s = e_ww + e_xx + e_yy + e_zz;
    num_nxt[0] = n_s - ((e_yy + e_zz) <<< 1);
    num_nxt[1] = (e_xy - e_wz) <<< 1;
    num_nxt[2] = (e_xz + e_wy) <<< 1;
    num_nxt[3] = (e_xy + e_wz) <<< 1;
    num_nxt[4] = n_s - ((e_xx + e_zz) <<< 1);
    num_nxt[5] = (e_yz - e_wx) <<< 1;
    num_nxt[6] = (e_xz - e_wy) <<< 1;
    num_nxt[7] = (e_yz + e_wx) <<< 1;
    num_nxt[8] = n_s - ((e_xx + e_yy) <<< 1);
    n_nxt = n_s[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (sum_rdy) begin
      n_r <= n_nxt;
      for (int i = 0; i < ELEMS; i++) begin
        num_r[i] <= num_nxt[i];
      end
    end
  end

  // ---------------- stage 3: dividend setup ----------------
  // rounded quotient = (|num| * 2^15 + n) / (2n); |num| <= n keeps it below 2^15
  div_stage_t div_r [DIV_STG+1];
  div_stage_t setup_nxt;

  always_comb begin
    logic signed [NUMW-1:0] mag;
    logic [DW-1:0]          dvd;
    mag = '0;
    dvd = '0;
    setup_nxt.dv   = {n_r, 1'b0};
    setup_nxt.zero = (n_r == '0);
    for (int i = 0; i < ELEMS; i++) begin
      mag = num_r[i][NUMW-1] ? -num_r[i] : num_r[i];
      dvd = {mag[NW-1:0], QBITS'(0)} + DW'(n_r);
      setup_nxt.lane[i].rem = RW'(dvd[DW-1:QBITS]);
      setup_nxt.lane[i].lo  = dvd[QBITS-1:0];
      setup_nxt.lane[i].quo = '0;
      setup_nxt.lane[i].neg = num_r[i][NUMW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy[0]) begin
      div_r[0] <= setup_nxt;
    end
  end

  // ---------------- divider stages ----------------
  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    div_stage_t st_nxt;

    always_comb begin
      logic [RW-1:0] rem_sh;
      logic          ge;
      st_nxt = div_r[k];
      for (int i = 0; i < ELEMS; i++) begin
        for (int b = 0; b < BITS_PER_STG; b++) begin
          // remainder stays below 2n, so the dropped top bit is always zero
          rem_sh = {st_nxt.lane[i].rem[RW-2:0], st_nxt.lane[i].lo[QBITS-1]};
          ge = (rem_sh >= RW'(st_nxt.dv));
          st_nxt.lane[i].rem = ge ? (rem_sh - RW'(st_nxt.dv)) : rem_sh;
          st_nxt.lane[i].lo  = {st_nxt.lane[i].lo[QBITS-2:0], 1'b0};
          st_nxt.lane[i].quo = {st_nxt.lane[i].quo[QBITS-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (d_rdy[k+1]) begin
        div_r[k+1] <= st_nxt;
      end
    end
  end

  // ---------------- output stage ----------------
  q2rm_out_t       out_data_r, out_nxt;
  logic signed [15:0] el [ELEMS];

  always_comb begin
    logic signed [15:0] mag_q;
    mag_q = '0;
    for (int i = 0; i < ELEMS; i++) begin
      // quotient never exceeds 16384, so it fits the Q2.14 range with no clamp needed
      mag_q = signed'(16'(div_r[DIV_STG].lane[i].quo));
      if (div_r[DIV_STG].zero) begin
        el[i] = (i == 0 || i == 4 || i == 8) ? 16'(Q_ONE) : '0;
      end else begin
        el[i] = div_r[DIV_STG].lane[i].neg ? -mag_q : mag_q;
      end
    end
    out_nxt.m_row0_col0 = el[0];
    out_nxt.m_row0_col1 = el[1];
    out_nxt.m_row0_col2 = el[2];
    out_nxt.m_row1_col0 = el[3];
    out_nxt.m_row1_col1 = el[4];
    out_nxt.m_row1_col2 = el[5];
    out_nxt.m_row2_col0 = el[6];
    out_nxt.m_row2_col1 = el[7];
    out_nxt.m_row2_col2 = el[8];
    out_nxt.zero_norm   = div_r[DIV_STG].zero;
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r    <= 1'b0;
      sum_v_r     <= 1'b0;
      div_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (prod_rdy) begin
        prod_v_r <= in_valid;
      end
      if (sum_rdy) begin
        sum_v_r <= prod_v_r;
      end
      if (d_rdy[0]) begin
        div_v_r[0] <= sum_v_r;
      end
      for (int k = 0; k < DIV_STG; k++) begin
        if (d_rdy[k+1]) begin
          div_v_r[k+1] <= div_v_r[k];
        end
      end
      if (out_rdy) begin
        out_valid_r <= div_v_r[DIV_STG];
      end
    end
  end

endmodule

### rtl/core/q2rm_checker.sv
// q2rm_checker: port-level checks for quaternion_to_rotation_matrix_unit
// bound to the top level below
// depends on q2rm_pkg
module q2rm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input q2rm_pkg::q2rm_in_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input q2rm_pkg::q2rm_out_t out_data
);
  import q2rm_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("q2rm: stalled request changed");

  // an empty output register means nothing in the pipe can block the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("q2rm: input blocked with empty output");

  // zero norm gives the identity
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |->
      out_data.m_row0_col0 == 16'(Q_ONE) && out_data.m_row1_col1 == 16'(Q_ONE) &&
      out_data.m_row2_col2 == 16'(Q_ONE) && out_data.m_row0_col1 == '0 &&
      out_data.m_row0_col2 == '0 && out_data.m_row1_col0 == '0 &&
      out_data.m_row1_col2 == '0 && out_data.m_row2_col0 == '0 &&
      out_data.m_row2_col1 == '0)
    else $error("q2rm: zero quaternion without identity");

  // normalized diagonal stays within one
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.m_row0_col0 <= 16'sd16384 && out_data.m_row0_col0 >= -16'sd16384 &&
      out_data.m_row1_col1 <= 16'sd16384 && out_data.m_row1_col1 >= -16'sd16384 &&
      out_data.m_row2_col2 <= 16'sd16384 && out_data.m_row2_col2 >= -16'sd16384)
    else $error("q2rm: diagonal element out of range");

endmodule

bind quaternion_to_rotation_matrix_unit q2rm_checker u_q2rm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
